// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, sampled on every rising clock edge outside reset.
`define EHT_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define EHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/eht_pkg.sv =====
package eht_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  localparam logic [1:0] RSP_OK   = 2'd0;
  localparam logic [1:0] RSP_MISS = 2'd1;
  localparam logic [1:0] RSP_FULL = 2'd2;

  // key byte sum of up to eight bytes fits 11 bits
  localparam int unsigned SUM_W = 11;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key;
    logic [31:0] record_handle;
  } eht_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_handle;
  } eht_rsp_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] handle;
  } eht_slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIR_RD,
    ST_BKT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_INS_CHK,
    ST_DBL_RD,
    ST_DBL_WR,
    ST_SPLIT_B,
    ST_SPLIT_NB,
    ST_REP_RD,
    ST_REP_WR,
    ST_MV_RD,
    ST_MV_WR
  } eht_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_DIR_RD,
    OP_BKT,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_INS_CHK,
    OP_DBL_RD,
    OP_DBL_WR,
    OP_SPLIT_B,
    OP_SPLIT_NB,
    OP_REP_RD,
    OP_REP_WR,
    OP_MV_RD,
    OP_MV_WR
  } eht_op_e;

  typedef struct packed {
    eht_op_e    op;
    logic       resp;
    logic [1:0] status;
  } eht_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       hit;
    logic       s_last;
    logic       i_last;
    logic       free;
    logic       pool_full;
    logic       ld_ge_gd;
    logic       gd_max;
  } eht_sts_t;

endpackage

// ===== src/eht_ctrl.sv =====
module eht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  eht_pkg::eht_sts_t sts_i,
  output eht_pkg::eht_cmd_t cmd_o,
  output logic              busy_o
);
  import eht_pkg::*;

  eht_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: OP_NONE, resp: 1'b0, status: RSP_OK};
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = ST_DIR_RD;
        end
      end
      ST_DIR_RD: begin
        if (sts_i.req_type == REQ_NOP) begin
          cmd_o.resp = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.op = OP_DIR_RD;
          state_d  = ST_BKT;
        end
      end
      ST_BKT: begin
        cmd_o.op = OP_BKT;
        state_d  = (sts_i.req_type == REQ_INSERT) ? ST_INS_CHK : ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        cmd_o.op = OP_SCAN_RD;
        state_d  = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd_o.op = OP_SCAN_CMP;
        if (sts_i.hit) begin
          cmd_o.resp = 1'b1;
          state_d    = ST_IDLE;
        end else if (sts_i.s_last) begin
          cmd_o.resp   = 1'b1;
          cmd_o.status = RSP_MISS;
          state_d      = ST_IDLE;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_INS_CHK: begin
        cmd_o.op = OP_INS_CHK;
        if (sts_i.free) begin
          cmd_o.resp = 1'b1;
          state_d    = ST_IDLE;
        end else if (sts_i.pool_full || (sts_i.ld_ge_gd && sts_i.gd_max)) begin
          cmd_o.resp   = 1'b1;
          cmd_o.status = RSP_FULL;
          state_d      = ST_IDLE;
        end else if (sts_i.ld_ge_gd) begin
          state_d = ST_DBL_RD;
        end else begin
          state_d = ST_SPLIT_B;
        end
      end
      ST_DBL_RD: begin
        cmd_o.op = OP_DBL_RD;
        state_d  = ST_DBL_WR;
      end
      ST_DBL_WR: begin
        cmd_o.op = OP_DBL_WR;
        state_d  = sts_i.i_last ? ST_SPLIT_B : ST_DBL_RD;
      end
      ST_SPLIT_B: begin
        cmd_o.op = OP_SPLIT_B;
        state_d  = ST_SPLIT_NB;
      end
      ST_SPLIT_NB: begin
        cmd_o.op = OP_SPLIT_NB;
        state_d  = ST_REP_RD;
      end
      ST_REP_RD: begin
        cmd_o.op = OP_REP_RD;
        state_d  = ST_REP_WR;
      end
      ST_REP_WR: begin
        cmd_o.op = OP_REP_WR;
        state_d  = sts_i.i_last ? ST_MV_RD : ST_REP_RD;
      end
      ST_MV_RD: begin
        cmd_o.op = OP_MV_RD;
        state_d  = ST_MV_WR;
      end
      ST_MV_WR: begin
        cmd_o.op = OP_MV_WR;
        state_d  = sts_i.s_last ? ST_DIR_RD : ST_MV_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== src/eht_dp.sv =====
`include "assert_macros.svh"

module eht_dp #(
  parameter int unsigned BUCKET_SLOTS     = 4,
  parameter int unsigned MAX_GLOBAL_DEPTH = 6,
  parameter int unsigned NUM_BUCKETS      = 64,
  parameter int unsigned KEY_BYTES        = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  eht_pkg::eht_req_t req_i,
  input  eht_pkg::eht_cmd_t cmd_i,
  output eht_pkg::eht_sts_t sts_o,
  output eht_pkg::eht_rsp_t rsp_o,
  output logic              done_o
);
  import eht_pkg::*;

  localparam int unsigned DW       = MAX_GLOBAL_DEPTH;
  localparam int unsigned DIR_SIZE = 1 << MAX_GLOBAL_DEPTH;
  localparam int unsigned LDW      = $clog2(MAX_GLOBAL_DEPTH + 1);
  localparam int unsigned BW       = $clog2(NUM_BUCKETS);
  localparam int unsigned UW       = BW + 1;
  localparam int unsigned SIW      = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int unsigned SLOTS    = NUM_BUCKETS * BUCKET_SLOTS;
  localparam int unsigned SAW      = $clog2(SLOTS);

  function automatic logic [63:0] key_trim(input logic [63:0] k);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < KEY_BYTES) begin
        r[8*i +: 8] = k[8*i +: 8];
      end
    end
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] key_sum(input logic [63:0] k);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < KEY_BYTES) begin
        s = s + SUM_W'(k[8*i +: 8]);
      end
    end
    return s;
  endfunction

  function automatic logic [SAW-1:0] slot_addr(input logic [BW-1:0] b, input logic [SIW-1:0] s);
    return SAW'(SAW'(b) * SAW'(BUCKET_SLOTS) + SAW'(s));
  endfunction

  eht_req_t          req_q;
  logic [SUM_W-1:0]  sum_q;
  logic [LDW-1:0]    gd_q;
  logic [UW-1:0]     used_q;
  logic              ld0_q;
  logic [BW-1:0]     b_q, nb_q;
  logic [LDW-1:0]    nl_q;
  logic [SIW-1:0]    s_q, fill_q;
  logic [DW-1:0]     i_q;
  logic [DW-1:0]     dra_q;
  logic [BUCKET_SLOTS-1:0] vld_q [NUM_BUCKETS];
  eht_rsp_t          rsp_q;
  logic              done_q;

  logic [BW-1:0]     dir_mem [DIR_SIZE];
  logic [BW-1:0]     dir_rd_q;
  logic [LDW-1:0]    ld_mem [NUM_BUCKETS];
  logic [LDW-1:0]    ld_rd_q;
  eht_slot_t         slot_mem [SLOTS];
  eht_slot_t         slot_rd_q;

  logic [DW-1:0]     mask, span, dir_idx, dir_ra;
  logic [BW-1:0]     dir_val;
  logic [LDW-1:0]    ld_b, bitpos;
  logic [BUCKET_SLOTS-1:0] row;
  logic [SIW-1:0]    ff;
  logic              hit, mv_bit, rep_bit, mv_en, rep_en;
  logic [SUM_W-1:0]  sum_mv;
  logic              dir_re, slot_re, slot_we;
  logic [SAW-1:0]    slot_ra, slot_wa;
  eht_slot_t         slot_wd;

  assign mask    = ~({DW{1'b1}} << gd_q);
  assign span    = DW'(1) << gd_q;
  assign dir_idx = sum_q[DW-1:0] & mask;
  assign dir_val = (dra_q == '0) ? '0 : dir_rd_q;
  assign ld_b    = ((b_q == '0) && !ld0_q) ? '0 : ld_rd_q;
  assign row     = vld_q[b_q];
  assign bitpos  = nl_q - 1'b1;
  assign sum_mv  = key_sum(slot_rd_q.key);
  assign mv_bit  = |((sum_mv >> bitpos) & SUM_W'(1));
  assign rep_bit = |((i_q >> bitpos) & DW'(1));
  assign hit     = row[s_q] && (slot_rd_q.key == req_q.key);
  assign mv_en   = (cmd_i.op == OP_MV_WR) && row[s_q] && mv_bit;
  assign rep_en  = (cmd_i.op == OP_REP_WR) && (dir_val == b_q) && rep_bit;

  always_comb begin
    ff = '0;
    for (int j = BUCKET_SLOTS - 1; j >= 0; j--) begin
      if (!row[j]) begin
        ff = SIW'(j);
      end
    end
  end

  always_comb begin
    dir_re  = 1'b0;
    dir_ra  = i_q;
    slot_re = 1'b0;
    slot_ra = slot_addr(b_q, s_q);
    slot_we = 1'b0;
    slot_wa = slot_addr(nb_q, fill_q);
    slot_wd = slot_rd_q;
    case (cmd_i.op)
      OP_DIR_RD: begin
        dir_re = 1'b1;
        dir_ra = dir_idx;
      end
      OP_DBL_RD, OP_REP_RD: begin
        dir_re = 1'b1;
      end
      OP_SCAN_RD, OP_MV_RD: begin
        slot_re = 1'b1;
      end
      OP_INS_CHK: begin
        slot_we = ~&row;
        slot_wa = slot_addr(b_q, ff);
        slot_wd = '{key: req_q.key, handle: req_q.record_handle};
      end
      OP_MV_WR: begin
        slot_we = mv_en;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dir_re) begin
      dir_rd_q <= dir_mem[dir_ra];
      dra_q    <= dir_ra;
    end
    if (cmd_i.op == OP_DBL_WR) begin
      dir_mem[i_q + span] <= dir_val;
    end else if (rep_en) begin
      dir_mem[i_q] <= nb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_BKT) begin
      ld_rd_q <= ld_mem[dir_val];
    end
    if (cmd_i.op == OP_SPLIT_B) begin
      ld_mem[b_q] <= ld_b + 1'b1;
    end else if (cmd_i.op == OP_SPLIT_NB) begin
      ld_mem[nb_q] <= nl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_ra];
    end
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gd_q   <= '0;
      used_q <= UW'(1);
      ld0_q  <= 1'b0;
      done_q <= 1'b0;
      for (int k = 0; k < NUM_BUCKETS; k++) begin
        vld_q[k] <= '0;
      end
    end else begin
      done_q <= cmd_i.resp;
      case (cmd_i.op)
        OP_SCAN_CMP: begin
          if (hit && (req_q.req_type == REQ_REMOVE)) begin
            vld_q[b_q][s_q] <= 1'b0;
          end
        end
        OP_INS_CHK: begin
          if (~&row) begin
            vld_q[b_q][ff] <= 1'b1;
          end
        end
        OP_DBL_WR: begin
          if (i_q == mask) begin
            gd_q <= gd_q + 1'b1;
          end
        end
        OP_SPLIT_B: begin
          used_q <= used_q + 1'b1;
          if (b_q == '0) begin
            ld0_q <= 1'b1;
          end
        end
        OP_MV_WR: begin
          if (mv_en) begin
            vld_q[b_q][s_q]     <= 1'b0;
            vld_q[nb_q][fill_q] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      rsp_q.status       <= cmd_i.status;
      rsp_q.found_handle <= ((cmd_i.op == OP_SCAN_CMP) && (req_q.req_type == REQ_LOOKUP) &&
                             (cmd_i.status == RSP_OK)) ? slot_rd_q.handle : '0;
    end
    case (cmd_i.op)
      OP_LATCH: begin
        req_q.req_type      <= req_i.req_type;
        req_q.key           <= key_trim(req_i.key);
        req_q.record_handle <= req_i.record_handle;
        sum_q               <= key_sum(req_i.key);
      end
      OP_BKT: begin
        b_q <= dir_val;
        s_q <= '0;
      end
      OP_SCAN_CMP: begin
        s_q <= s_q + 1'b1;
      end
      OP_INS_CHK: begin
        i_q <= '0;
      end
      OP_DBL_WR: begin
        i_q <= (i_q == mask) ? '0 : i_q + 1'b1;
      end
      OP_SPLIT_B: begin
        nb_q <= used_q[BW-1:0];
        nl_q <= ld_b + 1'b1;
        i_q  <= '0;
      end
      OP_SPLIT_NB: begin
        s_q    <= '0;
        fill_q <= '0;
      end
      OP_REP_WR: begin
        i_q <= i_q + 1'b1;
      end
      OP_MV_WR: begin
        s_q <= s_q + 1'b1;
        if (mv_en) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts_o.req_type  = req_q.req_type;
    sts_o.hit       = hit;
    sts_o.s_last    = (s_q == SIW'(BUCKET_SLOTS - 1));
    sts_o.i_last    = (i_q == mask);
    sts_o.free      = ~&row;
    sts_o.pool_full = (used_q == UW'(NUM_BUCKETS));
    sts_o.ld_ge_gd  = (ld_b >= gd_q);
    sts_o.gd_max    = (gd_q == LDW'(MAX_GLOBAL_DEPTH));
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

  `EHT_ASSERT_NEXT(a_resp_done, cmd_i.resp, done_q)
  `EHT_ASSERT(a_used_range, (used_q != '0) && (used_q <= UW'(NUM_BUCKETS)))
  `EHT_ASSERT(a_gd_range, gd_q <= LDW'(MAX_GLOBAL_DEPTH))
  `EHT_ASSERT_NEXT(a_split_used, cmd_i.op == OP_SPLIT_B, used_q == $past(used_q) + 1'b1)

endmodule

// ===== src/extendible_hash_table_unit.sv =====
// Extendible hash table. A request word is taken when start is high and busy is low;
// its result word appears on rsp_o for exactly one cycle with done_o high, in the cycle
// in which busy falls, and cannot be held off. An unused request type is answered from the
// directory read state, an insert into a bucket with room writes its first free slot, and a
// lookup or remove reads and compares the bucket slots one at a time. Each split runs a
// directory doubling pass when the directory doubles, then a directory repoint pass, a slot
// move pass and a new attempt from the directory read; these passes are set by the
// single-port directory and slot memories.
module extendible_hash_table_unit #(
  parameter int unsigned BUCKET_SLOTS     = 4,
  parameter int unsigned MAX_GLOBAL_DEPTH = 6,
  parameter int unsigned NUM_BUCKETS      = 64,
  parameter int unsigned KEY_BYTES        = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  eht_pkg::eht_req_t req_i,
  output logic              done_o,
  output eht_pkg::eht_rsp_t rsp_o
);
  import eht_pkg::*;

  eht_cmd_t cmd;
  eht_sts_t sts;

  eht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  eht_dp #(
    .BUCKET_SLOTS     (BUCKET_SLOTS),
    .MAX_GLOBAL_DEPTH (MAX_GLOBAL_DEPTH),
    .NUM_BUCKETS      (NUM_BUCKETS),
    .KEY_BYTES        (KEY_BYTES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule

// ===== tb/extendible_hash_table_checker.sv =====
module extendible_hash_table_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  eht_pkg::eht_req_t req_i,
  input  logic              done_o,
  input  eht_pkg::eht_rsp_t rsp_o,
  output int                fail_count_o,
  output int                words_due_o
);
  import eht_pkg::*;

  localparam int unsigned SLOTS    = 4;
  localparam int unsigned MAX_GD   = 6;
  localparam int unsigned BUCKETS  = 64;
  localparam int unsigned DIR_SIZE = 1 << MAX_GD;

  int unsigned gdepth;
  int unsigned dir_bucket [DIR_SIZE];
  int unsigned ldepth [BUCKETS];
  int unsigned fill [BUCKETS];
  int unsigned used_buckets;
  logic [63:0] keys [BUCKETS*SLOTS];
  logic [31:0] handles [BUCKETS*SLOTS];
  bit          valid [BUCKETS*SLOTS];

  eht_rsp_t rsp_due [$];

  function automatic int unsigned byte_sum(logic [63:0] k);
    int unsigned s;
    s = 0;
    for (int i = 0; i < 8; i++) s += k[8*i +: 8];
    return s;
  endfunction

  function automatic int unsigned bucket_of(logic [63:0] k);
    return dir_bucket[byte_sum(k) & ((1 << gdepth) - 1)];
  endfunction

  function automatic bit divide_bucket(int unsigned b);
    int unsigned nb, nl, span, src, dst;
    if (used_buckets >= BUCKETS) return 0;
    if (ldepth[b] >= gdepth) begin
      if (gdepth >= MAX_GD) return 0;
      span = 1 << gdepth;
      for (int i = 0; i < span; i++) dir_bucket[i + span] = dir_bucket[i];
      gdepth++;
    end
    nb = used_buckets++;
    nl = ldepth[b] + 1;
    ldepth[b] = nl;
    ldepth[nb] = nl;
    fill[nb] = 0;
    span = 1 << gdepth;
    for (int i = 0; i < span; i++)
      if (dir_bucket[i] == b && ((i >> (nl - 1)) & 1)) dir_bucket[i] = nb;
    for (int s = 0; s < SLOTS; s++) begin
      src = b * SLOTS + s;
      if (valid[src] && ((byte_sum(keys[src]) >> (nl - 1)) & 1)) begin
        dst = nb * SLOTS + fill[nb];
        keys[dst] = keys[src];
        handles[dst] = handles[src];
        valid[dst] = 1;
        fill[nb]++;
        valid[src] = 0;
        fill[b]--;
      end
    end
    return 1;
  endfunction

  function automatic logic [1:0] store_record(logic [63:0] k, logic [31:0] h);
    int unsigned b;
    for (int r = 0; r <= MAX_GD + 1; r++) begin
      b = bucket_of(k);
      if (fill[b] < SLOTS) begin
        for (int s = 0; s < SLOTS; s++)
          if (!valid[b*SLOTS + s]) begin
            keys[b*SLOTS + s] = k;
            handles[b*SLOTS + s] = h;
            valid[b*SLOTS + s] = 1;
            fill[b]++;
            return RSP_OK;
          end
        return RSP_FULL;
      end
      if (!divide_bucket(b)) return RSP_FULL;
    end
    return RSP_FULL;
  endfunction

  function automatic int match_slot(logic [63:0] k);
    int unsigned b;
    b = bucket_of(k);
    for (int s = 0; s < SLOTS; s++)
      if (valid[b*SLOTS + s] && keys[b*SLOTS + s] == k) return b*SLOTS + s;
    return -1;
  endfunction

  function automatic eht_rsp_t predict_response(eht_req_t rq);
    eht_rsp_t r;
    int at;
    r = '0;
    r.status = RSP_OK;
    case (rq.req_type)
      REQ_INSERT: r.status = store_record(rq.key, rq.record_handle);
      REQ_LOOKUP: begin
        at = match_slot(rq.key);
        if (at < 0) r.status = RSP_MISS;
        else r.found_handle = handles[at];
      end
      REQ_REMOVE: begin
        at = match_slot(rq.key);
        if (at < 0) r.status = RSP_MISS;
        else begin
          valid[at] = 0;
          if (fill[at / SLOTS] > 0) fill[at / SLOTS]--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    gdepth = 0;
    used_buckets = 1;
    foreach (dir_bucket[i]) dir_bucket[i] = 0;
    foreach (ldepth[i]) begin
      ldepth[i] = 0;
      fill[i] = 0;
    end
    foreach (valid[i]) valid[i] = 0;
  end

  assign words_due_o = rsp_due.size();

  always @(posedge clk_i) begin
    eht_rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (rsp_due.size() == 0) report("result word with none expected");
        else begin
          want = rsp_due.pop_front();
          if (rsp_o.status !== want.status)
            report($sformatf("status %0d, expected %0d", rsp_o.status, want.status));
          if (rsp_o.found_handle !== want.found_handle)
            report($sformatf("found_handle %h, expected %h",
                             rsp_o.found_handle, want.found_handle));
        end
      end
      if (start && !busy) rsp_due = {rsp_due, predict_response(req_i)};
    end
  end

  final begin
    if (rsp_due.size() != 0)
      $display("mismatch: %0d result words never arrived", rsp_due.size());
  end
endmodule

// ===== tb/extendible_hash_table_unit_test.sv =====
module extendible_hash_table_unit_test;
  import eht_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic     clk_i = 0;
  logic     rst_ni = 0;
  logic     start = 0;
  logic     busy;
  eht_req_t req_i = '0;
  logic     done_o;
  eht_rsp_t rsp_o;
  int       fail_count;
  int       words_due;
  int       quiet_cycles = 0;
  logic [63:0] key_pool [64];

  always #4 clk_i = ~clk_i;

  extendible_hash_table_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  extendible_hash_table_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .fail_count_o(fail_count), .words_due_o(words_due)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] op, logic [63:0] k, logic [31:0] h);
    int gap;
    start <= 1;
    req_i <= '{req_type: op, key: k, record_handle: h};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    gap = ($urandom_range(0, 2) == 0) ? 0 :
          ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 9) < 6) return key_pool[$urandom_range(0, 63)];
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [1:0] op;
    int unsigned r;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // same byte sum, forces splits up to max depth then full
    for (int i = 0; i < 5; i++) send_word(REQ_INSERT, 64'h1 << (8*i), 32'h100 + i);
    send_word(REQ_INSERT, 64'h1, 32'hFFFF_FFFF);
    send_word(REQ_LOOKUP, 64'h1, 32'h0);
    send_word(REQ_REMOVE, 64'h1, 32'h0);
    send_word(REQ_LOOKUP, 64'h1, 32'h0);
    send_word(REQ_REMOVE, 64'h1, 32'h0);
    send_word(REQ_REMOVE, 64'h1, 32'h0);
    send_word(REQ_LOOKUP, 64'h100, 32'h0);
    send_word(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send_word(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_INSERT, 64'h0, 32'hA5A5_5A5A);
    send_word(REQ_LOOKUP, 64'h0, 32'h0);
    send_word(REQ_NOP, 64'h0, 32'h0);
    send_word(REQ_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_LOOKUP, 64'h1234, 32'h0);
    send_word(REQ_REMOVE, 64'h1234, 32'h0);
    start <= 0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    for (int n = 0; n < 1450; n++) begin
      r = $urandom_range(0, 99);
      if (n < 700) op = (r < 70) ? REQ_INSERT : (r < 85) ? REQ_LOOKUP : (r < 97) ? REQ_REMOVE
                                                : REQ_NOP;
      else op = (r < 40) ? REQ_INSERT : (r < 70) ? REQ_LOOKUP : (r < 95) ? REQ_REMOVE
                                      : REQ_NOP;
      send_word(op, pick_key(), $urandom);
    end
    start <= 0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
